@@ hw/rtl/itp_pkg.sv @@
// Package for the infix to postfix converter.
// Holds the stack size, character codes, helper functions and the
// controller/datapath interface types. No dependencies.
`timescale 1ns / 1ps

package itp_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = $clog2(STACK_DEPTH);

  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_NUL    = 8'h00;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHAR,
    ST_CLOSE,
    ST_END,
    ST_FLUSH
  } ctrl_state_t;

  typedef enum logic [1:0] {
    EM_NONE,
    EM_TOP,
    EM_CHAR,
    EM_END
  } emit_src_t;

  typedef struct packed {
    logic      load;
    logic      push_char;
    logic      pop;
    emit_src_t emit_src;
    logic      emit_final;
    logic      finish;
    logic      clear;
  } itp_cmd_t;

  typedef struct packed {
    logic is_letter;
    logic is_open;
    logic is_close;
    logic is_last;
    logic empty;
    logic top_open;
    logic top_ge;
    logic out_free;
    logic pend_valid;
  } itp_status_t;

  function automatic logic [1:0] prec_of(input logic [7:0] c);
    logic [1:0] p;
    p = 2'd0;
    if (c == CH_PLUS || c == CH_MINUS) p = 2'd1;
    else if (c == CH_STAR || c == CH_SLASH) p = 2'd2;
    else if (c == CH_CARET) p = 2'd3;
    return p;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z);
  endfunction

endpackage

@@ hw/rtl/infix_to_postfix_converter.sv @@
// Top level of the infix to postfix converter (shunting-yard).
// Instantiates itp_controller and itp_datapath; depends on itp_pkg.
`timescale 1ns / 1ps

// Usage
// The input channel (in_valid/in_ready) takes one item per character of an
// infix expression, with last_of_expr set on its final character. The block
// behaves as if the expression were wrapped in parentheses. The output
// channel (out_valid/out_ready) delivers the postfix characters, and after
// the final character an end record with is_end set and out_char zero.
// last_of_run marks the final result caused by an input item; overflowed
// reports a push dropped on a full stack within the current expression.
// Timing: an item is taken only while the controller is idle. The controller
// loads it in ST_IDLE and works on it in ST_CHAR, staying there while it pops
// operators: the stack pops one entry per cycle while the output register has
// room, and each popped operator emits one character. A final character then
// passes ST_CLOSE, which pops the operators of the implicit close and then
// discards the implicit '(' (or finds the stack empty), then ST_END, which
// makes the end record, and ST_FLUSH, which flushes it. Results reach the
// output register directly or through a one-deep pending slot. When the
// receiver stalls, the controller holds while the output register is full;
// the input side is not blocked by a result that waits there. Synchronous
// reset empties the stack, clears the overflow flag and idles the controller.

module infix_to_postfix_converter (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_code,
  input  logic       last_of_expr,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       is_end,
  output logic       last_of_run,
  output logic       overflowed
);
  import itp_pkg::*;

  itp_cmd_t    cmd;
  itp_status_t status;

  // Sequencer: one state per phase of an item (character, implicit close,
  // end record, final flush).
  itp_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Stack, pending result and output register.
  itp_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .char_code    (char_code),
    .last_of_expr (last_of_expr),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char     (out_char),
    .is_end       (is_end),
    .last_of_run  (last_of_run),
    .overflowed   (overflowed)
  );

  // A new item never starts while a result of the previous one is pending.
  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !status.pend_valid)
    else $error("pending result left over when taking a new item");

  // The end record always closes the run of its item.
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_end) |-> (last_of_run && out_char == CH_NUL))
    else $error("end record malformed");

  // Taking a final character moves the controller out of idle, so in_ready drops.
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && last_of_expr) |=> !in_ready)
    else $error("final character finished without an end record");

endmodule

@@ hw/rtl/itp_datapath.sv @@
// Datapath of the infix to postfix converter: operator stack, input
// latch, one-deep pending result and output register.
// Depends on itp_pkg.
`timescale 1ns / 1ps

module itp_datapath (
  input  logic                clk,
  input  logic                rst,
  input  itp_pkg::itp_cmd_t   cmd,
  output itp_pkg::itp_status_t status,
  input  logic [7:0]          char_code,
  input  logic                last_of_expr,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_char,
  output logic                is_end,
  output logic                last_of_run,
  output logic                overflowed
);
  import itp_pkg::*;

  logic [7:0]       stack_mem [STACK_DEPTH];
  logic [CNT_W-1:0] stack_count;
  logic             at_start;
  logic             ovf_flag;
  logic [7:0]       char_reg;
  logic             last_reg;

  logic             pend_valid;
  logic [7:0]       pend_char;
  logic             pend_end;
  logic             pend_ovf;

  logic [IDX_W-1:0] top_idx;
  logic [7:0]       top_char;
  logic             empty;
  logic             full;
  logic             push_en;
  logic [7:0]       push_data;
  logic             emit_valid;
  logic [7:0]       emit_char;
  logic             emit_end;
  logic             out_load;

  assign top_idx   = IDX_W'(stack_count - CNT_W'(1));
  assign top_char  = stack_mem[top_idx];
  assign empty     = (stack_count == '0);
  assign full      = (stack_count == CNT_W'(STACK_DEPTH));
  assign push_en   = cmd.push_char | (cmd.load & at_start);
  assign push_data = cmd.load ? CH_LPAREN : char_reg;

  always_comb begin
    emit_valid = 1'b1;
    emit_end   = 1'b0;
    case (cmd.emit_src)
      EM_NONE: begin
        emit_valid = 1'b0;
        emit_char  = CH_NUL;
      end
      EM_TOP:  emit_char = top_char;
      EM_CHAR: emit_char = char_reg;
      EM_END: begin
        emit_char = CH_NUL;
        emit_end  = 1'b1;
      end
      default: begin
        emit_valid = 1'b0;
        emit_char  = CH_NUL;
      end
    endcase
  end

  // The output register is loaded by a direct final emit, by a new emit
  // that displaces the pending result, or by the flush at item end.
  assign out_load = (emit_valid & (cmd.emit_final | pend_valid)) | (cmd.finish & pend_valid);

  always_ff @(posedge clk) begin
    if (push_en && !full) begin
      stack_mem[stack_count[IDX_W-1:0]] <= push_data;
    end
    if (cmd.load) begin
      char_reg <= char_code;
      last_reg <= last_of_expr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_count <= '0;
      at_start    <= 1'b1;
      ovf_flag    <= 1'b0;
      pend_valid  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.clear) begin
        stack_count <= '0;
        at_start    <= 1'b1;
        ovf_flag    <= 1'b0;
      end else begin
        if (cmd.load) at_start <= 1'b0;
        if (push_en) begin
          if (full) ovf_flag <= 1'b1;
          else stack_count <= stack_count + CNT_W'(1);
        end else if (cmd.pop && !empty) begin
          stack_count <= stack_count - CNT_W'(1);
        end
      end
      if (emit_valid && !cmd.emit_final) begin
        pend_valid <= 1'b1;
      end else if (cmd.finish) begin
        pend_valid <= 1'b0;
      end
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_valid && cmd.emit_final) begin
      out_char    <= emit_char;
      is_end      <= emit_end;
      last_of_run <= 1'b1;
      overflowed  <= ovf_flag;
    end else if (out_load) begin
      out_char    <= pend_char;
      is_end      <= pend_end;
      last_of_run <= !emit_valid;
      overflowed  <= pend_ovf;
    end
    if (emit_valid && !cmd.emit_final) begin
      pend_char <= emit_char;
      pend_end  <= emit_end;
      pend_ovf  <= ovf_flag;
    end
  end

  always_comb begin
    status.is_letter  = is_letter(char_reg);
    status.is_open    = (char_reg == CH_LPAREN);
    status.is_close   = (char_reg == CH_RPAREN);
    status.is_last    = last_reg;
    status.empty      = empty;
    status.top_open   = (top_char == CH_LPAREN);
    status.top_ge     = !empty && (prec_of(top_char) >= prec_of(char_reg));
    status.out_free   = !out_valid || out_ready;
    status.pend_valid = pend_valid;
  end

endmodule

@@ hw/rtl/itp_controller.sv @@
// Controller of the infix to postfix converter: sequences the pops,
// pushes and emits of one item through the datapath.
// Depends on itp_pkg.
`timescale 1ns / 1ps

module itp_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  itp_pkg::itp_status_t status,
  output itp_pkg::itp_cmd_t    cmd
);
  import itp_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        go;
  logic        close_pop;
  logic        op_pop;

  // Every working step may load the output register, so it waits for room.
  assign go        = status.out_free;
  assign close_pop = !status.empty && !status.top_open;
  assign op_pop    = status.top_ge;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CHAR;
      end
      ST_CHAR: begin
        if (go) begin
          if (status.is_letter) begin
            state_next = status.is_last ? ST_CLOSE : ST_IDLE;
          end else if (status.is_open) begin
            state_next = status.is_last ? ST_CLOSE : ST_IDLE;
          end else if (status.is_close) begin
            if (!close_pop) state_next = status.is_last ? ST_CLOSE : ST_IDLE;
          end else begin
            if (!op_pop) state_next = status.is_last ? ST_CLOSE : ST_IDLE;
          end
        end
      end
      ST_CLOSE: begin
        if (go && !close_pop) state_next = ST_END;
      end
      ST_END: begin
        if (go) state_next = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (go) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    cmd.load       = 1'b0;
    cmd.push_char  = 1'b0;
    cmd.pop        = 1'b0;
    cmd.emit_src   = EM_NONE;
    cmd.emit_final = 1'b0;
    cmd.finish     = 1'b0;
    cmd.clear      = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_CHAR: begin
        if (go) begin
          if (status.is_letter) begin
            cmd.emit_src   = EM_CHAR;
            cmd.emit_final = !status.is_last;
          end else if (status.is_open) begin
            cmd.push_char = 1'b1;
            cmd.finish    = !status.is_last;
          end else if (status.is_close) begin
            cmd.pop = 1'b1;
            if (close_pop) cmd.emit_src = EM_TOP;
            else cmd.finish = !status.is_last;
          end else begin
            if (op_pop) begin
              cmd.pop      = 1'b1;
              cmd.emit_src = EM_TOP;
            end else begin
              cmd.push_char = 1'b1;
              cmd.finish    = !status.is_last;
            end
          end
        end
      end
      ST_CLOSE: begin
        if (go) begin
          cmd.pop = 1'b1;
          if (close_pop) cmd.emit_src = EM_TOP;
        end
      end
      ST_END: begin
        if (go) begin
          cmd.emit_src = EM_END;
          cmd.clear    = 1'b1;
        end
      end
      ST_FLUSH: begin
        cmd.finish = go;
      end
      default: begin
        cmd.finish = 1'b0;
      end
    endcase
  end

endmodule

@@ verif/testbench.sv @@
// Testbench for infix_to_postfix_converter: streams infix characters into the block
// and checks every postfix character and end record against its own shunting-yard predictor.
// Depends on itp_pkg (stack depth and character codes) and the converter RTL.
`timescale 1ns / 1ps

module testbench;
  import itp_pkg::*;

  // Characters on either side of the letter ranges, plus the top code.
  // None of them is a letter, so all of them act as precedence-0 operators.
  localparam logic [7:0] CH_BELOW_UPPER = CH_UPPER_A - 8'd1;
  localparam logic [7:0] CH_ABOVE_UPPER = CH_UPPER_Z + 8'd1;
  localparam logic [7:0] CH_BELOW_LOWER = CH_LOWER_A - 8'd1;
  localparam logic [7:0] CH_ABOVE_LOWER = CH_LOWER_Z + 8'd1;
  localparam logic [7:0] CH_TOP_CODE    = 8'hFF;

  localparam int RANDOM_ITEMS = 360;
  localparam int IDLE_PERCENT = 16;
  // The longest run of results is a full stack popped in one go plus the end
  // record, and the quiet period after the drain covers that tail.
  localparam int DRAIN_CYCLES = 80;
  // The slowest correct run is far below this, even with every item
  // producing its longest run and every result waiting out receiver stalls.
  localparam int CYCLE_LIMIT  = 400000;

  // One expected output item of the converter.
  typedef struct packed {
    logic [7:0] ch;
    logic       end_rec;
    logic       run_last;
    logic       ovf;
  } postfix_rec_t;

  // The scoreboard holds a copy of the operator stack and predicts the postfix
  // output of every accepted character. Results are checked in order.
  class postfix_scoreboard;
    logic [7:0]   op_stack [STACK_DEPTH];
    int           depth_used;
    bit           expr_open;
    bit           ovf_seen;
    postfix_rec_t run_q[$];
    postfix_rec_t expected_postfix[$];
    int           errors;

    function new();
      depth_used = 0;
      expr_open  = 1'b0;
      ovf_seen   = 1'b0;
      errors     = 0;
    endfunction

    function int op_rank(logic [7:0] c);
      case (c)
        CH_PLUS, CH_MINUS: return 1;
        CH_STAR, CH_SLASH: return 2;
        CH_CARET:          return 3;
        default:           return 0;
      endcase
    endfunction

    function bit is_alpha(logic [7:0] c);
      return (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z);
    endfunction

    function void emit(logic [7:0] c, logic end_rec);
      postfix_rec_t r;
      r.ch       = c;
      r.end_rec  = end_rec;
      r.run_last = 1'b0;
      r.ovf      = ovf_seen;
      run_q.push_back(r);
    endfunction

    // A push onto a full stack is dropped and flags overflow for the expression.
    function void push(logic [7:0] c);
      if (depth_used >= STACK_DEPTH) begin
        ovf_seen = 1'b1;
      end else begin
        op_stack[depth_used] = c;
        depth_used++;
      end
    endfunction

    // Pop and emit down to the nearest '(' and discard it; without one the
    // stack simply empties.
    function void close_group();
      while (depth_used > 0 && op_stack[depth_used - 1] != CH_LPAREN) begin
        depth_used--;
        emit(op_stack[depth_used], 1'b0);
      end
      if (depth_used > 0) depth_used--;
    endfunction

    function void note_char(logic [7:0] c, logic last);
      int rank;
      run_q.delete();
      if (!expr_open) begin
        push(CH_LPAREN);
        expr_open = 1'b1;
      end
      if (is_alpha(c)) begin
        emit(c, 1'b0);
      end else if (c == CH_LPAREN) begin
        push(c);
      end else if (c == CH_RPAREN) begin
        close_group();
      end else begin
        rank = op_rank(c);
        while (depth_used > 0 && op_rank(op_stack[depth_used - 1]) >= rank) begin
          depth_used--;
          emit(op_stack[depth_used], 1'b0);
        end
        push(c);
      end
      if (last) begin
        close_group();
        emit(CH_NUL, 1'b1);
        depth_used = 0;
        ovf_seen   = 1'b0;
        expr_open  = 1'b0;
      end
      if (run_q.size() > 0) run_q[run_q.size() - 1].run_last = 1'b1;
      foreach (run_q[i]) expected_postfix.push_back(run_q[i]);
    endfunction

    function void check_postfix_char(logic [7:0] ch, logic end_rec, logic run_last, logic ovf);
      postfix_rec_t exp_rec;
      if (expected_postfix.size() == 0) begin
        $error("unexpected result: out_char %h is_end %b", ch, end_rec);
        errors++;
        return;
      end
      exp_rec = expected_postfix.pop_front();
      if (ch !== exp_rec.ch) begin
        $error("out_char: expected %h, got %h", exp_rec.ch, ch);
        errors++;
      end
      if (end_rec !== exp_rec.end_rec) begin
        $error("is_end: expected %b, got %b", exp_rec.end_rec, end_rec);
        errors++;
      end
      if (run_last !== exp_rec.run_last) begin
        $error("last_of_run: expected %b, got %b", exp_rec.run_last, run_last);
        errors++;
      end
      if (ovf !== exp_rec.ovf) begin
        $error("overflowed: expected %b, got %b", exp_rec.ovf, ovf);
        errors++;
      end
    endfunction

    function int pending();
      return expected_postfix.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] char_code = 8'h00;
  logic       last_of_expr = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_char;
  logic       is_end;
  logic       last_of_run;
  logic       overflowed;

  postfix_scoreboard sb = new();

  logic [7:0] expr_chars[$];
  int         items_sent = 0;
  int         cycle_count = 0;
  // While set, neither side inserts idle cycles.
  bit         no_idle = 1'b0;

  infix_to_postfix_converter i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .char_code    (char_code),
    .last_of_expr (last_of_expr),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char     (out_char),
    .is_end       (is_end),
    .last_of_run  (last_of_run),
    .overflowed   (overflowed)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The receiver drops ready at random, except during the no-idle stretch.
  always @(negedge clk) begin
    out_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);
  end

  // Every output item taken at a rising edge goes to the scoreboard. The
  // values read here are the ones that were present before the edge.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_postfix_char(out_char, is_end, last_of_run, overflowed);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [7:0] random_letter();
    if ($urandom_range(0, 1) == 1) return 8'(CH_UPPER_A + $urandom_range(0, 25));
    return 8'(CH_LOWER_A + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] random_operator();
    case ($urandom_range(0, 4))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      3:       return CH_SLASH;
      default: return CH_CARET;
    endcase
  endfunction

  // Offers one item and returns at the falling edge after it was accepted.
  // Valid is left high on return, so a following item goes out back to back
  // without lowering and raising valid in the same step.
  task automatic send_char(input logic [7:0] c, input logic last);
    if (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < IDLE_PERCENT);
    end
    in_valid     <= 1'b1;
    char_code    <= c;
    last_of_expr <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_char(c, last);
    items_sent++;
    @(negedge clk);
  endtask

  // Sends the buffered expression, with the end flag on its final character.
  task automatic send_expr();
    foreach (expr_chars[i]) send_char(expr_chars[i], i == expr_chars.size() - 1);
    expr_chars.delete();
  endtask

  // Holds the sender off until every expected result has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // A well-formed expression: operands joined by operators, with balanced
  // parentheses opened and closed at random points.
  task automatic build_wellformed();
    int n_operands;
    int open_groups;
    n_operands  = $urandom_range(1, 10);
    open_groups = 0;
    for (int i = 0; i < n_operands; i++) begin
      while (open_groups < 6 && $urandom_range(0, 3) == 0) begin
        expr_chars.push_back(CH_LPAREN);
        open_groups++;
      end
      expr_chars.push_back(random_letter());
      while (open_groups > 0 && $urandom_range(0, 2) == 0) begin
        expr_chars.push_back(CH_RPAREN);
        open_groups--;
      end
      if (i < n_operands - 1) expr_chars.push_back(random_operator());
    end
    repeat (open_groups) expr_chars.push_back(CH_RPAREN);
  endtask

  // Arbitrary bytes: digits, spaces, codes above 127 and so on.
  task automatic build_noise();
    repeat ($urandom_range(1, 8)) expr_chars.push_back(8'($urandom_range(0, 255)));
  endtask

  // Valid tokens in any order: stray parentheses, adjacent operators.
  task automatic build_broken();
    repeat ($urandom_range(1, 10)) begin
      case ($urandom_range(0, 3))
        0:       expr_chars.push_back(random_letter());
        1:       expr_chars.push_back(random_operator());
        2:       expr_chars.push_back(CH_LPAREN);
        default: expr_chars.push_back(CH_RPAREN);
      endcase
    end
  endtask

  // Deep nesting that fills the stack and often overflows it; the closing
  // parentheses then unwind long runs of pops.
  task automatic build_deep_nesting();
    int depth;
    depth = $urandom_range(STACK_DEPTH - 7, STACK_DEPTH + 8);
    repeat (depth) expr_chars.push_back(CH_LPAREN);
    expr_chars.push_back(random_letter());
    repeat ($urandom_range(0, 3)) begin
      expr_chars.push_back(random_operator());
      expr_chars.push_back(random_letter());
    end
    repeat ($urandom_range(0, depth + 2)) expr_chars.push_back(CH_RPAREN);
  endtask

  initial begin
    int  shape;
    bit  drained_once;
    drained_once = 1'b0;

    // Reset is held at the start, then released on a falling edge.
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part. Precedence between '+' and '*'.
    expr_chars = '{CH_LOWER_A, CH_PLUS, CH_UPPER_Z, CH_STAR, CH_LOWER_Z};
    send_expr();
    // Parentheses, '-', '/', and the left-associative '^'.
    expr_chars = '{CH_LPAREN, CH_UPPER_A, CH_MINUS, CH_LOWER_Z, CH_RPAREN, CH_SLASH,
                   CH_UPPER_Z, CH_CARET, CH_LOWER_A, CH_CARET, CH_UPPER_A};
    send_expr();
    // A lone ')' consumes the implicit '(' and leaves the final close with
    // an empty stack.
    expr_chars = '{CH_RPAREN};
    send_expr();
    // Precedence-0 characters at the edges of the code space and of the
    // letter ranges; each one pops everything, the implicit '(' included.
    expr_chars = '{CH_NUL, CH_TOP_CODE, CH_BELOW_UPPER, CH_ABOVE_UPPER,
                   CH_BELOW_LOWER, CH_ABOVE_LOWER};
    send_expr();
    // A single letter as a whole expression.
    expr_chars = '{CH_LOWER_Z};
    send_expr();

    // Random part. It opens with deep nesting, which often overflows the stack.
    build_deep_nesting();
    send_expr();
    while (items_sent < RANDOM_ITEMS + 24) begin
      // A stretch in the middle runs with no idle cycles on either side.
      no_idle = (items_sent >= 120 && items_sent < 220);
      shape = $urandom_range(0, 99);
      if (shape < 65)      build_wellformed();
      else if (shape < 80) build_noise();
      else if (shape < 92) build_broken();
      else                 build_deep_nesting();
      send_expr();
      if ((!drained_once && items_sent >= 200) || $urandom_range(0, 99) < 3) begin
        wait_drained();
        drained_once = 1'b1;
      end
    end
    no_idle = 1'b0;
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
    end
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
